// File: sv/jse_pkg.sv
// jse_pkg: shared types, character codes and helper functions of the JSON string escaper.
// Used by jse_front, jse_queue, jse_back and json_string_escaper_top; depends on nothing.
`default_nettype none

package jse_pkg;

   // Output form of one decoded character.
   localparam logic [1:0] KIND_CHAR = 2'd0;  // one character as is
   localparam logic [1:0] KIND_PAIR = 2'd1;  // backslash and a letter
   localparam logic [1:0] KIND_U6   = 2'd2;  // one backslash-u escape
   localparam logic [1:0] KIND_U12  = 2'd3;  // surrogate pair of escapes

   localparam logic [20:0] REPLACEMENT_CP = 21'h00FFFD;
   localparam logic [7:0]  CHAR_BACKSLASH = 8'h5C;
   localparam logic [7:0]  CHAR_U         = 8'h75;
   localparam logic [7:0]  CHAR_NONE      = 8'h00;

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] word_hi;  // character, letter, or first escape value
      logic [15:0] word_lo;  // second escape value of a surrogate pair
   } token_type;

   // One queue word: the characters caused by one input byte.
   typedef struct packed {
      token_type tok0;
      token_type tok1;
      logic      two;      // tok1 is present
      logic      str_end;  // byte closed the string
      logic      err;      // sticky error flag including this byte
   } entry_type;

   // Escape letter of a special character, CHAR_NONE for all others.
   function automatic logic [7:0] escape_letter(input logic [20:0] cp);
      logic [7:0] letter;
      unique case (cp)
         21'h000008: letter = 8'h62;  // b
         21'h00000C: letter = 8'h66;  // f
         21'h00000A: letter = 8'h6E;  // n
         21'h00000D: letter = 8'h72;  // r
         21'h000009: letter = 8'h74;  // t
         21'h00005C: letter = 8'h5C;  // backslash
         21'h000022: letter = 8'h22;  // double quote
         default:    letter = CHAR_NONE;
      endcase
      return letter;
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      logic [7:0] c;
      if (nib < 4'd10) begin
         c = 8'h30 + {4'h0, nib};
      end else begin
         c = 8'h37 + {4'h0, nib};
      end
      return c;
   endfunction

   // Classify a code point (or a raw byte in simple mode) into its output form.
   function automatic token_type make_token(input logic [20:0] cp, input logic raw);
      token_type  t;
      logic [7:0] letter;
      logic [20:0] v;
      letter    = escape_letter(cp);
      v         = cp - 21'h010000;
      t.kind    = KIND_CHAR;
      t.word_hi = {8'h00, cp[7:0]};
      t.word_lo = 16'h0000;
      if (letter != CHAR_NONE) begin
         t.kind    = KIND_PAIR;
         t.word_hi = {8'h00, letter};
      end else if (raw || (cp < 21'h000080 && cp >= 21'h000020)) begin
         t.kind = KIND_CHAR;
      end else if (cp <= 21'h00FFFF) begin
         t.kind    = KIND_U6;
         t.word_hi = cp[15:0];
      end else begin
         t.kind    = KIND_U12;
         t.word_hi = {6'b110110, v[19:10]};
         t.word_lo = {6'b110111, v[9:0]};
      end
      return t;
   endfunction

endpackage

`default_nettype wire

// File: sv/json_string_escaper_top.sv
// json_string_escaper_top: JSON string escaper, UTF-8 bytes in, escaped ASCII characters out.
// Depends on jse_pkg, jse_front, jse_queue and jse_back.
//
// Usage:
//   req_*  : one string byte per word (req_in_byte), req_string_end on the last byte.
//   rsp_*  : one output character per word; rsp_run_last marks the last character of a
//            byte, rsp_string_done the last of the string, rsp_encoding_error is the
//            sticky malformed-UTF-8 flag, shown only with rsp_string_done.
//   csr_*  : write csr_unicode_mode (1 decodes UTF-8, 0 escapes only the seven specials)
//            while the block is idle; csr_ready is always high. A write drops any open
//            UTF-8 sequence.
//   Path: the characters of an accepted byte pass through the queue and then the output
//   register before they are offered.
//   Throughput: one character per cycle at the output register while rsp_ready is high; a
//   byte yielding one character sustains one byte per cycle. Escapes take 2, 6 or 12
//   characters, which the back part emits one per cycle. Lead bytes of a sequence
//   produce no word.
//   A QUEUE_DEPTH-word queue decouples decoding from output, so the front keeps taking
//   bytes while rsp_ready is low until the queue fills; the output word holds.
//   Reset: empties the queue and output register, clears the decoder and error flag,
//   and selects unicode mode.
`default_nettype none

module json_string_escaper_top #(
   parameter int QUEUE_DEPTH = 4
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_in_byte,
   input  wire logic       req_string_end,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [7:0]      rsp_out_char,
   output logic            rsp_run_last,
   output logic            rsp_string_done,
   output logic            rsp_encoding_error,
   input  wire logic       csr_valid,
   output logic            csr_ready,
   input  wire logic       csr_unicode_mode
);

   jse_pkg::entry_type push_word, head_word;
   logic q_push, q_pop, q_full, q_empty;

   // Register writes are taken at once.
   assign csr_ready = 1'b1;

   // Front: decode and classify one byte per cycle while the queue is not full.
   jse_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .in_byte    (req_in_byte),
      .string_end (req_string_end),
      .csr_write  (csr_valid && csr_ready),
      .csr_data   (csr_unicode_mode),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_entry    (push_word)
   );

   // Queue: hold decoded words while the back part is busy.
   jse_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (push_word),
      .pop       (q_pop),
      .head      (head_word),
      .full      (q_full),
      .empty     (q_empty)
   );

   // Back: expand each word into characters.
   jse_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head           (head_word),
      .q_empty        (q_empty),
      .q_pop          (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .out_char       (rsp_out_char),
      .run_last       (rsp_run_last),
      .string_done    (rsp_string_done),
      .encoding_error (rsp_encoding_error)
   );

   // End of string is always the last character of its byte.
   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_string_done |-> rsp_run_last)
      else $error("string_done without run_last");

   // Error flag appears only with the end of the string.
   a_err_with_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_encoding_error |-> rsp_string_done)
      else $error("encoding_error outside string_done");

   // Never pop an empty queue.
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("queue popped while empty");

   // Output register is empty right after reset.
   a_reset_clears: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("rsp_valid high after reset");

endmodule

`default_nettype wire

// File: sv/jse_front.sv
// jse_front: accepts string bytes, runs the UTF-8 decoder and classifies the result.
// Writes one queue word per byte that causes output; depends on jse_pkg.
`default_nettype none

module jse_front (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [7:0]         in_byte,
   input  wire logic               string_end,
   input  wire logic               csr_write,
   input  wire logic               csr_data,
   input  wire logic               q_full,
   output logic                    q_push,
   output jse_pkg::entry_type      q_entry
);

   logic        mode_ff, mode_in;
   logic [20:0] pcp_ff, pcp_in;
   logic [1:0]  bse_ff, bse_in;
   logic [1:0]  slen_ff, slen_in;
   logic        err_ff, err_in;

   logic [20:0] dec_pcp;
   logic [1:0]  dec_bse;
   logic [1:0]  dec_slen;
   logic        e_a, mid_v, mid_bad, e_d, any_out;
   logic [20:0] mid_cp, acc;
   logic [7:0]  lower, upper;
   logic        in_range, do_start, accept;
   jse_pkg::entry_type ent;

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;
   assign acc       = {pcp_ff[14:0], in_byte[5:0]};

   always_comb begin
      lower = 8'h80;
      upper = 8'hBF;
      if (bse_ff == slen_ff) begin
         if (slen_ff == 2'd2 && pcp_ff == 21'h0) lower = 8'hA0;
         if (slen_ff == 2'd2 && pcp_ff == 21'hD) upper = 8'h9F;
         if (slen_ff == 2'd3 && pcp_ff == 21'h0) lower = 8'h90;
         if (slen_ff == 2'd3 && pcp_ff == 21'h4) upper = 8'h8F;
      end
      in_range = (in_byte >= lower) && (in_byte <= upper);
      do_start = (bse_ff == 2'd0) || !in_range;
      e_a      = (bse_ff != 2'd0) && !in_range;

      dec_pcp  = pcp_ff;
      dec_bse  = bse_ff;
      dec_slen = slen_ff;
      mid_v    = 1'b0;
      mid_bad  = 1'b0;
      mid_cp   = 21'h0;
      if (do_start) begin
         dec_pcp  = 21'h0;
         dec_bse  = 2'd0;
         dec_slen = 2'd0;
         if (in_byte < 8'h80) begin
            mid_v  = 1'b1;
            mid_cp = {13'h0, in_byte};
         end else if (in_byte >= 8'hC2 && in_byte <= 8'hDF) begin
            dec_pcp  = {16'h0, in_byte[4:0]};
            dec_bse  = 2'd1;
            dec_slen = 2'd1;
         end else if (in_byte >= 8'hE0 && in_byte <= 8'hEF) begin
            dec_pcp  = {17'h0, in_byte[3:0]};
            dec_bse  = 2'd2;
            dec_slen = 2'd2;
         end else if (in_byte >= 8'hF0 && in_byte <= 8'hF4) begin
            dec_pcp  = {18'h0, in_byte[2:0]};
            dec_bse  = 2'd3;
            dec_slen = 2'd3;
         end else begin
            mid_v   = 1'b1;
            mid_bad = 1'b1;
            mid_cp  = jse_pkg::REPLACEMENT_CP;
         end
      end else begin
         dec_pcp = acc;
         dec_bse = bse_ff - 2'd1;
         if (bse_ff == 2'd1) begin
            mid_v    = 1'b1;
            mid_cp   = acc;
            dec_pcp  = 21'h0;
            dec_slen = 2'd0;
         end
      end
      // Truncated sequence at the end of the string.
      e_d = string_end && (dec_bse != 2'd0);

      if (mode_ff) begin
         any_out      = e_a || mid_v || e_d;
         ent.two      = (e_a && mid_v) || (e_a && e_d) || (mid_v && e_d);
         ent.err      = err_ff || e_a || mid_bad || e_d;
         ent.tok0     = jse_pkg::make_token(
                           e_a ? jse_pkg::REPLACEMENT_CP :
                           (mid_v ? mid_cp : jse_pkg::REPLACEMENT_CP), 1'b0);
         ent.tok1     = jse_pkg::make_token(
                           (e_a && mid_v) ? mid_cp : jse_pkg::REPLACEMENT_CP, 1'b0);
      end else begin
         any_out      = 1'b1;
         ent.two      = 1'b0;
         ent.err      = err_ff;
         ent.tok0     = jse_pkg::make_token({13'h0, in_byte}, 1'b1);
         ent.tok1     = ent.tok0;
      end
      ent.str_end = string_end;
   end

   assign q_push  = accept && any_out;
   assign q_entry = ent;

   always_comb begin
      mode_in = mode_ff;
      pcp_in  = pcp_ff;
      bse_in  = bse_ff;
      slen_in = slen_ff;
      err_in  = err_ff;
      if (csr_write) begin
         // Mode change drops any open sequence, keeps the error flag.
         mode_in = csr_data;
         pcp_in  = 21'h0;
         bse_in  = 2'd0;
         slen_in = 2'd0;
      end else if (accept) begin
         if (string_end) begin
            pcp_in  = 21'h0;
            bse_in  = 2'd0;
            slen_in = 2'd0;
            err_in  = 1'b0;
         end else if (mode_ff) begin
            pcp_in  = dec_pcp;
            bse_in  = dec_bse;
            slen_in = dec_slen;
            err_in  = ent.err;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b1;
         pcp_ff  <= 21'h0;
         bse_ff  <= 2'd0;
         slen_ff <= 2'd0;
         err_ff  <= 1'b0;
      end else begin
         mode_ff <= mode_in;
         pcp_ff  <= pcp_in;
         bse_ff  <= bse_in;
         slen_ff <= slen_in;
         err_ff  <= err_in;
      end
   end

endmodule

`default_nettype wire

// File: sv/jse_queue.sv
// jse_queue: short queue of decoded words between the front and back parts.
// Depends on jse_pkg for the word type.
`default_nettype none

module jse_queue #(
   parameter int DEPTH = 4
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire jse_pkg::entry_type push_data,
   input  wire logic               pop,
   output jse_pkg::entry_type      head,
   output logic                    full,
   output logic                    empty
);

   localparam int CW = $clog2(DEPTH + 1);

   // Slot 0 always holds the oldest word; a pop shifts every slot down by one.
   jse_pkg::entry_type slot_ff [DEPTH];
   jse_pkg::entry_type slot_in [DEPTH];
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] wr_pos;

   assign full  = (count_ff == CW'(DEPTH));
   assign empty = (count_ff == '0);
   assign head  = slot_ff[0];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CW'(1);
      end
      // A word pushed together with a pop lands one slot lower.
      wr_pos = pop ? count_ff - CW'(1) : count_ff;
      for (int i = 0; i < DEPTH; i++) begin
         slot_in[i] = slot_ff[i];
      end
      if (pop) begin
         for (int i = 0; i < DEPTH - 1; i++) begin
            slot_in[i] = slot_ff[i + 1];
         end
      end
      if (push) begin
         for (int i = 0; i < DEPTH; i++) begin
            if (wr_pos == CW'(i)) begin
               slot_in[i] = push_data;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

// File: sv/jse_back.sv
// jse_back: expands queued words into escaped characters, one per cycle unless stalled, into the output register.
// Depends on jse_pkg.
`default_nettype none

module jse_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire jse_pkg::entry_type head,
   input  wire logic               q_empty,
   output logic                    q_pop,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [7:0]              out_char,
   output logic                    run_last,
   output logic                    string_done,
   output logic                    encoding_error
);

   logic [3:0]  idx_ff, idx_in;
   logic        sel_ff, sel_in;
   logic        valid_ff, valid_in;
   logic [7:0]  char_ff, char_in;
   logic        last_ff, last_in;
   logic        done_ff, done_in;
   logic        err_ff, err_in;

   jse_pkg::token_type tok;
   logic [3:0]  tok_len, j;
   logic [15:0] w;
   logic [7:0]  ch;
   logic        tok_last, ent_last, load;

   assign tok  = sel_ff ? head.tok1 : head.tok0;
   assign load = !q_empty && (!valid_ff || rsp_ready);

   always_comb begin
      unique case (tok.kind)
         jse_pkg::KIND_CHAR: tok_len = 4'd1;
         jse_pkg::KIND_PAIR: tok_len = 4'd2;
         jse_pkg::KIND_U6:   tok_len = 4'd6;
         jse_pkg::KIND_U12:  tok_len = 4'd12;
         default:            tok_len = 4'd1;
      endcase
      // Second escape of a surrogate pair starts at character six.
      if (idx_ff >= 4'd6) begin
         j = idx_ff - 4'd6;
         w = tok.word_lo;
      end else begin
         j = idx_ff;
         w = tok.word_hi;
      end
      unique case (tok.kind)
         jse_pkg::KIND_CHAR: ch = tok.word_hi[7:0];
         jse_pkg::KIND_PAIR: ch = (idx_ff == 4'd0) ? jse_pkg::CHAR_BACKSLASH
                                                   : tok.word_hi[7:0];
         default: begin
            case (j)
               4'd0:    ch = jse_pkg::CHAR_BACKSLASH;
               4'd1:    ch = jse_pkg::CHAR_U;
               4'd2:    ch = jse_pkg::hex_char(w[15:12]);
               4'd3:    ch = jse_pkg::hex_char(w[11:8]);
               4'd4:    ch = jse_pkg::hex_char(w[7:4]);
               4'd5:    ch = jse_pkg::hex_char(w[3:0]);
               default: ch = jse_pkg::CHAR_NONE;
            endcase
         end
      endcase
      tok_last = (idx_ff == tok_len - 4'd1);
      ent_last = tok_last && (sel_ff == head.two);
   end

   assign q_pop = load && ent_last;

   always_comb begin
      idx_in   = idx_ff;
      sel_in   = sel_ff;
      valid_in = valid_ff;
      char_in  = char_ff;
      last_in  = last_ff;
      done_in  = done_ff;
      err_in   = err_ff;
      if (load) begin
         valid_in = 1'b1;
         char_in  = ch;
         last_in  = ent_last;
         done_in  = ent_last && head.str_end;
         err_in   = ent_last && head.str_end && head.err;
         if (ent_last) begin
            idx_in = 4'd0;
            sel_in = 1'b0;
         end else if (tok_last) begin
            idx_in = 4'd0;
            sel_in = 1'b1;
         end else begin
            idx_in = idx_ff + 4'd1;
         end
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= 4'd0;
         sel_ff   <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         sel_ff   <= sel_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      char_ff <= char_in;
      last_ff <= last_in;
      done_ff <= done_in;
      err_ff  <= err_in;
   end

   assign rsp_valid      = valid_ff;
   assign out_char       = char_ff;
   assign run_last       = last_ff;
   assign string_done    = done_ff;
   assign encoding_error = err_ff;

endmodule

`default_nettype wire
